// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

    // Job codes decided by the front end
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_FULL   = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_FORWARDED   = 3'd0;
    localparam logic [2:0] ST_TTL_EXPIRED = 3'd1;
    localparam logic [2:0] ST_NO_ROUTE    = 3'd2;
    localparam logic [2:0] ST_ADDED       = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;
    localparam logic [7:0] TTL_MIN        = 8'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic        has_hop;
        logic [31:0] hop;
        logic [2:0]  port;
        logic [7:0]  ttl;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  intf;
        logic [31:0] hop;
        logic [7:0]  ttl;
    } t_result;

endpackage

// ===== rtl/lpr_front.sv =====
module lpr_front #(
    parameter int TABLE_DEPTH = 64,
    parameter int PORT_COUNT  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_full,
    input  logic           i_cmd,
    input  logic [31:0]    i_address,
    input  logic [5:0]     i_prefix_len,
    input  logic           i_has_next_hop,
    input  logic [31:0]    i_next_hop_addr,
    input  logic [2:0]     i_interface_index,
    input  logic [7:0]     i_ttl_in,
    output logic           o_ready,
    output logic           o_push,
    output lpr_pkg::t_job  o_job
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0] r_add_count;
    logic [CW-1:0] n_add_count;
    logic [2:0]    port_sat;
    logic          table_full;

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign table_full = (r_add_count == CW'(TABLE_DEPTH));

    // Clamp out-of-range interfaces to the highest one present
    always_comb begin
        port_sat = i_interface_index;
        if (PORT_COUNT < 8 && int'(i_interface_index) >= PORT_COUNT) begin
            port_sat = 3'(PORT_COUNT - 1);
        end
    end

    always_comb begin
        o_job.addr    = i_address;
        o_job.plen    = i_prefix_len;
        o_job.has_hop = i_has_next_hop;
        o_job.hop     = i_next_hop_addr;
        o_job.port    = port_sat;
        o_job.ttl     = i_ttl_in;
        n_add_count   = r_add_count;
        if (!i_cmd) begin
            if (table_full) begin
                o_job.op = lpr_pkg::OP_FULL;
            end else begin
                o_job.op = lpr_pkg::OP_ADD;
                if (o_push) begin
                    n_add_count = r_add_count + CW'(1);
                end
            end
        end else if (i_ttl_in <= lpr_pkg::TTL_MIN) begin
            o_job.op = lpr_pkg::OP_EXPIRE;
        end else begin
            o_job.op = lpr_pkg::OP_LOOKUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_count <= '0;
        end else begin
            r_add_count <= n_add_count;
        end
    end

endmodule

// ===== rtl/lpr_fifo.sv =====
module lpr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpr_pkg::t_job  i_job,
    input  logic           i_pop,
    output lpr_pkg::t_job  o_job,
    output logic           o_empty,
    output logic           o_full
);

    lpr_pkg::t_job r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_level;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_level == 2'd0);
    assign o_full  = (r_level == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ===== rtl/lpr_back.sv =====
module lpr_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  lpr_pkg::t_job     i_job,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output lpr_pkg::t_result  o_res
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic        has_hop;
        logic [31:0] hop;
        logic [2:0]  port;
    } t_entry;

    t_entry mem [TABLE_DEPTH];

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_issue, n_issue;
    logic             r_pending, n_pending;
    logic             r_found, n_found;
    logic [5:0]       r_best_len, n_best_len;
    logic [2:0]       r_best_port, n_best_port;
    logic [31:0]      r_best_hop, n_best_hop;
    lpr_pkg::t_job    r_job, n_job;
    lpr_pkg::t_result r_res, n_res;
    lpr_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;
    t_entry           r_rd_data;
    t_entry           wr_data;
    logic             wr_en;
    logic             rd_en;
    logic [31:0]      mask;
    logic             hit;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign wr_en   = (r_state == S_RUN) && (r_job.op == lpr_pkg::OP_ADD);
    assign rd_en   = (r_state == S_SCAN) && (r_issue != r_count);

    assign wr_data.prefix  = r_job.addr;
    assign wr_data.len     = r_job.plen;
    assign wr_data.has_hop = r_job.has_hop;
    assign wr_data.hop     = r_job.hop;
    assign wr_data.port    = r_job.port;

    // Prefix mask of the entry just read; lengths above 32 never match
    always_comb begin
        if (r_rd_data.len == 6'd0) begin
            mask = '0;
        end else begin
            mask = 32'hFFFF_FFFF << (lpr_pkg::MAX_PREFIX_LEN - r_rd_data.len);
        end
        hit = (r_rd_data.len <= lpr_pkg::MAX_PREFIX_LEN)
           && (((r_job.addr ^ r_rd_data.prefix) & mask) == 32'd0);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pending   = 1'b0;
        n_found     = r_found;
        n_best_len  = r_best_len;
        n_best_port = r_best_port;
        n_best_hop  = r_best_hop;
        n_job       = r_job;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_job   = i_job;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_res   = '0;
                n_state = S_OUT;
                case (r_job.op)
                    lpr_pkg::OP_ADD: begin
                        n_count      = r_count + CW'(1);
                        n_res.status = lpr_pkg::ST_ADDED;
                    end
                    lpr_pkg::OP_FULL: begin
                        n_res.status = lpr_pkg::ST_FULL;
                    end
                    lpr_pkg::OP_EXPIRE: begin
                        n_res.status = lpr_pkg::ST_TTL_EXPIRED;
                    end
                    lpr_pkg::OP_LOOKUP: begin
                        if (r_count == '0) begin
                            n_res.status = lpr_pkg::ST_NO_ROUTE;
                        end else begin
                            n_issue = '0;
                            n_found = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_issue   = r_issue + CW'(1);
                    n_pending = 1'b1;
                end
                // Strictly longer wins, so the earlier entry keeps a tie
                if (r_pending && hit && (!r_found || r_rd_data.len > r_best_len)) begin
                    n_found     = 1'b1;
                    n_best_len  = r_rd_data.len;
                    n_best_port = r_rd_data.port;
                    n_best_hop  = r_rd_data.has_hop ? r_rd_data.hop : r_job.addr;
                end
                if (!rd_en && !r_pending) begin
                    n_res = '0;
                    if (r_found) begin
                        n_res.status = lpr_pkg::ST_FORWARDED;
                        n_res.intf   = r_best_port;
                        n_res.hop    = r_best_hop;
                        n_res.ttl    = r_job.ttl - 8'd1;
                    end else begin
                        n_res.status = lpr_pkg::ST_NO_ROUTE;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_issue[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue     <= n_issue;
        r_best_len  <= n_best_len;
        r_best_port <= n_best_port;
        r_best_hop  <= n_best_hop;
        r_job       <= n_job;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ipv4_longest_prefix_router.sv =====
// Channel   Dir  Handshake              Payload
// s_*       in   i_s_tvalid/o_s_tready  tuser: cmd; tdata: route add or datagram header
// m_*       out  o_m_tvalid/i_m_tready  tdata: status, interface, hop address, ttl
//
// Add, full and expired items go from the job queue through the job and result registers
// to the output register; a lookup first scans the table, one table entry per cycle through
// the single read port of the route memory. A two-beat job queue sits between
// classifier and table, so beats are accepted while a result waits at the output
// register. Reset (synchronous, active low) empties the table by clearing the fill count.
module ipv4_longest_prefix_router #(
    parameter int TABLE_DEPTH = 64,
    parameter int PORT_COUNT  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] address, [37:32] prefix_len, [38] has_next_hop,
    // [70:39] next_hop_addr, [73:71] interface_index, [81:74] ttl_in, [87:82] zero
    input  logic [87:0] i_s_tdata,
    // [0] cmd
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] status, [5:3] out_interface, [37:6] hop_addr, [45:38] ttl_out, [47:46] zero
    output logic [47:0] o_m_tdata
);

    lpr_pkg::t_job    front_job;
    lpr_pkg::t_job    queue_job;
    lpr_pkg::t_result result;
    logic             push;
    logic             pop;
    logic             queue_empty;
    logic             queue_full;

    // Classify each beat and hold the fill count for table-full decisions
    lpr_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_tvalid),
        .i_full            (queue_full),
        .i_cmd             (i_s_tuser),
        .i_address         (i_s_tdata[31:0]),
        .i_prefix_len      (i_s_tdata[37:32]),
        .i_has_next_hop    (i_s_tdata[38]),
        .i_next_hop_addr   (i_s_tdata[70:39]),
        .i_interface_index (i_s_tdata[73:71]),
        .i_ttl_in          (i_s_tdata[81:74]),
        .o_ready           (o_s_tready),
        .o_push            (push),
        .o_job             (front_job)
    );

    // Decouple the classifier from the table scan
    lpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    // Store routes and run the longest-match scan
    lpr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_job   (queue_job),
        .o_pop   (pop),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (result)
    );

    assign o_m_tdata = {2'b00, result.ttl, result.hop, result.intf, result.status};

    // Forwarded beats always carry a live ttl
    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tdata[2:0] == lpr_pkg::ST_FORWARDED)
        |-> (o_m_tdata[45:38] != 8'd0))
        else $error("forwarded beat with zero ttl");

    // Every other status zeroes the remaining fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] != lpr_pkg::ST_FORWARDED)
        |-> (o_m_tdata[45:3] == 43'd0))
        else $error("non-forwarded beat carries data");

    // Chosen interface stays within the ports present
    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] == lpr_pkg::ST_FORWARDED)
        |-> (PORT_COUNT >= 8 || int'(o_m_tdata[5:3]) < PORT_COUNT))
        else $error("interface beyond port count");

endmodule
